// ----- src/int2roman_pkg.sv -----
// Shared types, constants and letter tables for the integer to Roman numeral block.
// Used by int2roman_ctrl, int2roman_dp and integer_to_roman_numeral.
`timescale 1ns / 1ps

package int2roman_pkg;

  localparam int ValueWidth  = 12;
  localparam int LetterWidth = 8;
  localparam int BcdWidth    = 16;
  localparam int WeightWidth = 14;

  localparam logic [ValueWidth-1:0] MaxValue = ValueWidth'(3999);

  // Decimal places, most significant first
  localparam logic [1:0] PlaceThousands = 2'd3;
  localparam logic [1:0] PlaceHundreds  = 2'd2;
  localparam logic [1:0] PlaceTens      = 2'd1;
  localparam logic [1:0] PlaceUnits     = 2'd0;

  localparam logic [LetterWidth-1:0] LetterM = 8'h4D;
  localparam logic [LetterWidth-1:0] LetterD = 8'h44;
  localparam logic [LetterWidth-1:0] LetterC = 8'h43;
  localparam logic [LetterWidth-1:0] LetterL = 8'h4C;
  localparam logic [LetterWidth-1:0] LetterX = 8'h58;
  localparam logic [LetterWidth-1:0] LetterV = 8'h56;
  localparam logic [LetterWidth-1:0] LetterI = 8'h49;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    ROLE_ONE,
    ROLE_FIVE,
    ROLE_TEN
  } role_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_step;
    logic err_load;
  } cmd_t;

  typedef struct packed {
    logic range_err;
    logic conv_done;
    logic run_done;
    logic out_free;
  } status_t;

  // Value of digit k at a decimal place
  function automatic logic [WeightWidth-1:0] place_weight(input logic [1:0] place,
                                                          input logic [3:0] k);
    logic [WeightWidth-1:0] w;
    case (place)
      PlaceThousands: w = WeightWidth'(k) * WeightWidth'(1000);
      PlaceHundreds:  w = WeightWidth'(k) * WeightWidth'(100);
      PlaceTens:      w = WeightWidth'(k) * WeightWidth'(10);
      default:        w = WeightWidth'(k);
    endcase
    return w;
  endfunction

  // Number of letters a digit takes at a place; thousands are M repeated
  function automatic logic [2:0] digit_len(input logic [1:0] place, input logic [3:0] d);
    logic [2:0] len;
    if (place == PlaceThousands) begin
      len = d[2:0];
    end else begin
      case (d)
        4'd0:    len = 3'd0;
        4'd1:    len = 3'd1;
        4'd2:    len = 3'd2;
        4'd3:    len = 3'd3;
        4'd4:    len = 3'd2;
        4'd5:    len = 3'd1;
        4'd6:    len = 3'd2;
        4'd7:    len = 3'd3;
        4'd8:    len = 3'd4;
        4'd9:    len = 3'd2;
        default: len = 3'd0;
      endcase
    end
    return len;
  endfunction

  // Which of the one, five and ten letters sits at a position within a digit
  function automatic role_t digit_role(input logic [3:0] d, input logic [1:0] pos);
    role_t r;
    if (d == 4'd9) begin
      r = (pos == 2'd0) ? ROLE_ONE : ROLE_TEN;
    end else if (d == 4'd4) begin
      r = (pos == 2'd0) ? ROLE_ONE : ROLE_FIVE;
    end else if (d >= 4'd5) begin
      r = (pos == 2'd0) ? ROLE_FIVE : ROLE_ONE;
    end else begin
      r = ROLE_ONE;
    end
    return r;
  endfunction

  function automatic logic [LetterWidth-1:0] place_letter(input logic [1:0] place,
                                                          input role_t role);
    logic [LetterWidth-1:0] l;
    case (place)
      PlaceThousands: l = LetterM;
      PlaceHundreds: begin
        case (role)
          ROLE_ONE:  l = LetterC;
          ROLE_FIVE: l = LetterD;
          ROLE_TEN:  l = LetterM;
          default:   l = LetterC;
        endcase
      end
      PlaceTens: begin
        case (role)
          ROLE_ONE:  l = LetterX;
          ROLE_FIVE: l = LetterL;
          ROLE_TEN:  l = LetterC;
          default:   l = LetterX;
        endcase
      end
      default: begin
        case (role)
          ROLE_ONE:  l = LetterI;
          ROLE_FIVE: l = LetterV;
          ROLE_TEN:  l = LetterX;
          default:   l = LetterI;
        endcase
      end
    endcase
    return l;
  endfunction

endpackage

// ----- src/integer_to_roman_numeral.sv -----
// Top level of the integer to Roman numeral block.
// Instantiates int2roman_ctrl and int2roman_dp; depends on int2roman_pkg.
`timescale 1ns / 1ps

// Converts one 12-bit unsigned value into its Roman numeral, sent out as a
// run of ASCII letters (I V X L C D M), most significant place first, one
// letter per output transaction, with last set on the final letter. Values
// of 0 or above 3999 give a single transaction with letter 0, last 1 and
// error 1. One item is worked on at a time: after the input transaction the
// block pulls out the thousands, hundreds, tens and units digits by compare
// and subtract (one digit per cycle), then walks the digits, producing one
// letter per cycle while the output is not stalled and stepping over each
// zero digit it passes without a letter. The final letter sits in the output
// register while the next input transaction is taken, and output stall
// simply holds the letter sequencer.
module integer_to_roman_numeral (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [int2roman_pkg::ValueWidth-1:0]  value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [int2roman_pkg::LetterWidth-1:0] letter,
  output logic                                  last,
  output logic                                  error
);
  import int2roman_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the load, digit and letter steps
  int2roman_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the value, its decimal digits and the output register
  int2roman_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .letter    (letter),
    .last      (last),
    .error     (error)
  );

endmodule

// ----- src/int2roman_ctrl.sv -----
// Controller state machine for the integer to Roman numeral block.
// Depends on int2roman_pkg; drives commands to int2roman_dp.
`timescale 1ns / 1ps

module int2roman_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  int2roman_pkg::status_t  status,
  output int2roman_pkg::cmd_t     cmd
);
  import int2roman_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.range_err ? ST_ERR : ST_CONV;
        end
      end
      ST_CONV: begin
        if (status.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.run_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_IDLE);
    cmd           = '0;
    case (state)
      ST_IDLE: cmd.load      = in_valid;
      ST_CONV: cmd.conv_step = 1'b1;
      ST_EMIT: cmd.emit_step = status.out_free;
      ST_ERR:  cmd.err_load  = status.out_free;
      default: cmd           = '0;
    endcase
  end

endmodule

// ----- src/int2roman_dp.sv -----
// Datapath for the integer to Roman numeral block: decimal digit extractor,
// letter sequencer and output register. Depends on int2roman_pkg.
`timescale 1ns / 1ps

module int2roman_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [int2roman_pkg::ValueWidth-1:0]     value,
  input  int2roman_pkg::cmd_t                      cmd,
  output int2roman_pkg::status_t                   status,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [int2roman_pkg::LetterWidth-1:0]    letter,
  output logic                                     last,
  output logic                                     error
);
  import int2roman_pkg::*;

  logic [ValueWidth-1:0]  bin;
  logic [BcdWidth-1:0]    bcd;
  logic [1:0]             place;
  logic [1:0]             pos;

  logic [3:0]             conv_digit;
  logic [WeightWidth-1:0] conv_sub;
  logic [3:0]             digit;
  logic [2:0]             len;
  logic                   pos_end;
  logic                   lower_zero;
  logic                   out_free;

  // Compare the remainder against every multiple of the place weight;
  // the largest multiple that fits gives the digit
  always_comb begin
    conv_digit = 4'd0;
    conv_sub   = '0;
    for (int k = 1; k < 10; k++) begin
      if (WeightWidth'(bin) >= place_weight(place, 4'(k))) begin
        conv_digit = 4'(k);
        conv_sub   = place_weight(place, 4'(k));
      end
    end
  end

  always_comb begin
    digit   = bcd[{place, 2'b00} +: 4];
    len     = digit_len(place, digit);
    pos_end = (len == 3'd0) || ({1'b0, pos} == len - 3'd1);
    case (place)
      PlaceThousands: lower_zero = (bcd[11:0] == '0);
      PlaceHundreds:  lower_zero = (bcd[7:0] == '0);
      PlaceTens:      lower_zero = (bcd[3:0] == '0);
      default:        lower_zero = 1'b1;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.range_err = (value == '0) || (value > MaxValue);
    status.conv_done = (place == PlaceUnits);
    status.run_done  = pos_end && lower_zero;
    status.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin   <= value;
      bcd   <= '0;
      place <= PlaceThousands;
      pos   <= 2'd0;
    end else if (cmd.conv_step) begin
      // One digit per step; place wraps back to thousands after the units
      bcd[{place, 2'b00} +: 4] <= conv_digit;
      bin   <= bin - conv_sub[ValueWidth-1:0];
      place <= place - 2'd1;
    end else if (cmd.emit_step) begin
      // Advance to the next place once this digit's letters are out
      if (pos_end) begin
        pos   <= 2'd0;
        place <= place - 2'd1;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.err_load || (cmd.emit_step && len != 3'd0)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      letter <= '0;
      last   <= 1'b1;
      error  <= 1'b1;
    end else if (cmd.emit_step && len != 3'd0) begin
      letter <= place_letter(place, digit_role(digit, pos));
      last   <= pos_end && lower_zero;
      error  <= 1'b0;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for integer_to_roman_numeral: spells each accepted value
// in Roman letters and compares every output letter in order.
// Depends on int2roman_pkg and the integer_to_roman_numeral RTL only.
`timescale 1ns / 1ps

module tb_top;
  import int2roman_pkg::*;

  // One output transaction as the block should present it
  typedef struct packed {
    logic [LetterWidth-1:0] letter;
    logic                   last;
    logic                   error;
  } roman_char_t;

  // Spells accepted values into expected letters and checks them as they come
  class numeral_tracker;
    roman_char_t            pending_letters[$];
    logic [LetterWidth-1:0] spelled[$];
    int failures   = 0;
    int n_values   = 0;
    int n_rejected = 0;
    int n_letters  = 0;

    // Append the letters of one decimal digit given its one, five, ten letters
    function void spell_digit(int d, logic [LetterWidth-1:0] one,
                              logic [LetterWidth-1:0] five, logic [LetterWidth-1:0] ten);
      if (d == 9) begin
        spelled.push_back(one);
        spelled.push_back(ten);
      end else if (d == 4) begin
        spelled.push_back(one);
        spelled.push_back(five);
      end else begin
        if (d >= 5) begin
          spelled.push_back(five);
          d -= 5;
        end
        repeat (d) spelled.push_back(one);
      end
    endfunction

    // Called on each accepted input transaction
    function void note_value(logic [ValueWidth-1:0] v);
      int num;
      roman_char_t c;
      num = v;
      n_values++;
      if (num == 0 || num > MaxValue) begin
        // no numeral exists: one flagged, empty letter
        n_rejected++;
        c.letter = '0;
        c.last   = 1'b1;
        c.error  = 1'b1;
        pending_letters.push_back(c);
        return;
      end
      spelled.delete();
      repeat (num / 1000) spelled.push_back(LetterM);
      spell_digit((num / 100) % 10, LetterC, LetterD, LetterM);
      spell_digit((num / 10) % 10, LetterX, LetterL, LetterC);
      spell_digit(num % 10, LetterI, LetterV, LetterX);
      foreach (spelled[i]) begin
        c.letter = spelled[i];
        c.last   = (i == spelled.size() - 1);
        c.error  = 1'b0;
        pending_letters.push_back(c);
      end
    endfunction

    // Called on each accepted output transaction
    function void check_letter(logic [LetterWidth-1:0] letter, logic last, logic error);
      roman_char_t want;
      n_letters++;
      if (pending_letters.size() == 0) begin
        $error("letter 0x%02h (last %0b error %0b) arrived with nothing pending",
               letter, last, error);
        failures++;
        return;
      end
      want = pending_letters.pop_front();
      if (letter !== want.letter) begin
        $error("letter: expected 0x%02h, got 0x%02h", want.letter, letter);
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        failures++;
      end
      if (error !== want.error) begin
        $error("error: expected %0b, got %0b", want.error, error);
        failures++;
      end
    endfunction

    function int pending();
      return pending_letters.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [ValueWidth-1:0]  value     = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [LetterWidth-1:0] letter;
  logic                   last;
  logic                   error;

  // When set, hold valid high between values with no idle cycles
  bit back_to_back = 1'b0;

  numeral_tracker tracker = new;

  always #1 clk = ~clk;

  integer_to_roman_numeral i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .letter    (letter),
    .last      (last),
    .error     (error)
  );

  // Idle length before the next input: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 45) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Present one value and hold it until the block takes the transaction.
  // Valid stays high on exit so a following value can go out with no gap.
  task automatic send_value(input logic [ValueWidth-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    tracker.note_value(v);
  endtask

  // Random value: mostly in range, with some zeros and some above the limit
  function automatic logic [ValueWidth-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '0;
    end else if (r < 15) begin
      return ValueWidth'($urandom_range(4000, 4095));
    end
    return ValueWidth'($urandom_range(1, 3999));
  endfunction

  // Output side: free stretches of varied length, stalls mostly short, a few long
  initial begin
    int free_len;
    int hold_len;
    forever begin
      @(posedge clk);
      free_len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      hold_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (hold_len - 1) @(posedge clk);
    end
  end

  // Check every output transaction against the oldest pending letter
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_letter(letter, last, error);
    end
  end

  initial begin
    int unsigned corner_values[$];
    corner_values = '{
      0, 1, 3999, 4000, 4095,     // range edges and the out-of-range top
      3888, 3333, 1994, 444,      // longest run, repeats, mixed subtractive forms
      4, 9, 40, 90, 400, 900,     // subtractive forms at each place
      5, 50, 500,                 // lone five letters
      1000, 3000, 6,              // thousands alone, units alone
      2048, 2730, 1365, 3549      // single high bit, alternating and repeating bit patterns
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, sent back to back
    back_to_back = 1'b1;
    foreach (corner_values[i]) send_value(ValueWidth'(corner_values[i]));

    // Random part, with idle gaps between values
    back_to_back = 1'b0;
    repeat (105) send_value(pick_value());
    @(posedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every letter, then let the block settle
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Converted %0d values (%0d out of range) and checked %0d output letters.",
             tracker.n_values, tracker.n_rejected, tracker.n_letters);
    $display("Stalls and idle gaps were applied at random on both sides.");
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every stall at its longest
  initial begin
    #1_000_000;
    $display("Timed out with %0d letters still pending.", tracker.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule
